// ===== rtl/core/gne_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid neighbour expander package
// Shared widths, payload structs, codes and the divider interface types.
// ----------------------------------------------------------------------------
package gne_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned NodeW  = 12;
  localparam int unsigned CountW = 7;
  localparam int unsigned CellW  = 6;
  localparam int unsigned IdW    = 12;

  // Configuration port.
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register indexes, taken from paddr[2].
  localparam logic RegRowCount    = 1'b0;
  localparam logic RegColumnCount = 1'b1;

  // Reset values of the count registers.
  localparam logic [CountW-1:0] RowCountRst    = CountW'(64);
  localparam logic [CountW-1:0] ColumnCountRst = CountW'(64);

  // Default grid storage.
  localparam int unsigned MaxRowsDef = 64;
  localparam int unsigned MaxColsDef = 64;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [1:0] {
    MoveUp    = 2'd0,
    MoveDown  = 2'd1,
    MoveRight = 2'd2,
    MoveLeft  = 2'd3
  } move_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDiv,
    StRead,
    StEmit
  } state_e;

  typedef struct packed {
    logic             op;
    logic [CellW-1:0] cell_row;
    logic [CellW-1:0] cell_col;
    logic             cell_blocked;
    logic [NodeW-1:0] node_id;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] neighbor_id;
    logic           neighbor_valid;
    logic [1:0]     move_index;
    logic           last;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [NodeW-1:0]  dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [NodeW-1:0]  quotient;
    logic [CountW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/core/gne_divider.sv =====
// ----------------------------------------------------------------------------
// Grid neighbour expander divider
// Restoring divider: one quotient bit per cycle, node id by column count.
// ----------------------------------------------------------------------------
module gne_divider import gne_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(NodeW + 1);

  logic              busy_q;
  logic              done_q;
  logic [StepW-1:0]  step_q;
  logic [NodeW-1:0]  quo_q;
  logic [CountW-1:0] rem_q;
  logic [CountW-1:0] dsr_q;

  logic [CountW:0]   trial;
  logic [CountW:0]   diff;
  logic              ge;
  logic [CountW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, quo_q[NodeW-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
    // The partial remainder always stays below the divisor.
    rem_d = ge ? diff[CountW-1:0] : trial[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(NodeW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[NodeW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== rtl/core/grid_neighbor_expander_core.sv =====
// ----------------------------------------------------------------------------
// Grid neighbour expander
// Obstacle map in a one-bit memory; a query gives the four 4-connected
// neighbours of a node with their inside-and-free flags.
// ----------------------------------------------------------------------------
// A query runs the iterative divider over all NodeW (12) node id bits until it
// flags done; then each move takes a memory read state and an emit state, and
// the emit state waits while the output is stalled. The input stays stalled
// until the last move is emitted; a cell write is taken in idle. After reset a
// clearing pass over all 2**(RW+CW) addresses (4096 by default) zeroes the map.
// ----------------------------------------------------------------------------
module grid_neighbor_expander_core import gne_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDef,
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned Depth = 2 ** AW;

  // Configuration registers.
  logic [CountW-1:0] row_count_q;
  logic [CountW-1:0] col_count_q;
  logic [CountW-1:0] rows_eff;
  logic [CountW-1:0] cols_eff;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountRst;
      col_count_q <= ColumnCountRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegRowCount:    row_count_q <= pwdata[CountW-1:0];
        RegColumnCount: col_count_q <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegRowCount:    prdata = ApbDataW'(row_count_q);
      RegColumnCount: prdata = ApbDataW'(col_count_q);
      default:        prdata = '0;
    endcase
  end

  // A zero count acts as one; a count above the storage saturates to it.
  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = CountW'(1);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      rows_eff = CountW'(MAX_ROWS);
    end else begin
      rows_eff = row_count_q;
    end
    if (col_count_q == '0) begin
      cols_eff = CountW'(1);
    end else if (32'(col_count_q) > MAX_COLS) begin
      cols_eff = CountW'(MAX_COLS);
    end else begin
      cols_eff = col_count_q;
    end
  end

  // Control state.
  state_e    state_q, state_d;
  move_e     move_q, move_d;
  logic [AW-1:0] clr_addr_q;
  logic      in_accept;
  logic      out_free;

  // Per-move result registers.
  logic [IdW-1:0] id_q;
  logic           inside_q;
  logic           load_move;

  out_item_t out_q;
  logic      out_valid_q;
  logic      load_out;

  // Divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  gne_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  assign div_req.start    = in_accept & (in_item_i.op == OpQuery);
  assign div_req.dividend = in_item_i.node_id;
  assign div_req.divisor  = cols_eff;

  // Neighbour of the current move.
  logic [NodeW-1:0]    r;
  logic [CountW-1:0]   c;
  logic [NodeW:0]      nr;
  logic [CountW:0]     nc;
  logic                nbr_in_grid;
  logic [CountW-1:0]   nr_n;
  logic [2*CountW-1:0] id_full;

  always_comb begin
    r = div_rsp.quotient;
    c = div_rsp.remainder;
    unique case (move_q)
      MoveUp: begin
        nr          = {1'b0, r} - (NodeW + 1)'(1);
        nc          = {1'b0, c};
        nbr_in_grid = (r != '0) && (r <= NodeW'(rows_eff));
      end
      MoveDown: begin
        nr          = {1'b0, r} + (NodeW + 1)'(1);
        nc          = {1'b0, c};
        nbr_in_grid = (nr < (NodeW + 1)'(rows_eff));
      end
      MoveRight: begin
        nr          = {1'b0, r};
        nc          = {1'b0, c} + (CountW + 1)'(1);
        nbr_in_grid = (r < NodeW'(rows_eff)) && (nc < {1'b0, cols_eff});
      end
      MoveLeft: begin
        nr          = {1'b0, r};
        nc          = {1'b0, c} - (CountW + 1)'(1);
        nbr_in_grid = (r < NodeW'(rows_eff)) && (c != '0);
      end
    endcase
    // Inside the grid the neighbour row is below the row count.
    nr_n    = nr[CountW-1:0];
    id_full = nr_n * cols_eff + (2 * CountW)'(nc[CountW-1:0]);
  end

  // Obstacle memory, one bit per cell, addressed by row and column.
  logic          mem_q [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          rdata_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = 1'b0;
    if (state_q == StClear) begin
      mem_we = 1'b1;
    end else if (in_accept && (in_item_i.op == OpWrite)) begin
      // Writes beyond the stored rows or columns are dropped.
      mem_we    = (32'(in_item_i.cell_row) < MAX_ROWS) &&
                  (32'(in_item_i.cell_col) < MAX_COLS);
      mem_waddr = {RW'(in_item_i.cell_row), CW'(in_item_i.cell_col)};
      mem_wdata = in_item_i.cell_blocked;
    end
  end

  assign mem_re    = (state_q == StRead);
  assign mem_raddr = {RW'(nr_n), CW'(nc[CountW-1:0])};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    move_d    = move_q;
    load_move = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      StClear: begin
        if (clr_addr_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (div_req.start) begin
          state_d = StDiv;
          move_d  = MoveUp;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          state_d = StRead;
        end
      end
      StRead: begin
        load_move = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          load_out = 1'b1;
          unique case (move_q)
            MoveUp:    begin move_d = MoveDown;  state_d = StRead; end
            MoveDown:  begin move_d = MoveRight; state_d = StRead; end
            MoveRight: begin move_d = MoveLeft;  state_d = StRead; end
            MoveLeft:  begin move_d = MoveUp;    state_d = StIdle; end
          endcase
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      move_q      <= MoveUp;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      move_q  <= move_d;
      if (state_q == StClear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_move) begin
      id_q     <= nbr_in_grid ? id_full[IdW-1:0] : '0;
      inside_q <= nbr_in_grid;
    end
    if (load_out) begin
      out_q.neighbor_id    <= id_q;
      out_q.neighbor_valid <= inside_q & ~rdata_q;
      out_q.move_index     <= move_q;
      out_q.last           <= (move_q == MoveLeft);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== test/grid_neighbor_expander_core_tb.sv =====
// ----------------------------------------------------------------------------
// Grid neighbour expander testbench
// Writes obstacle cells and queries nodes over several grid shapes. The
// expected neighbour transfers are worked out from a local obstacle map and
// compared field by field with each result. Both handshakes idle at random,
// and one long output hold-off fills the block up.
// ----------------------------------------------------------------------------
module grid_neighbor_expander_core_tb;
  import gne_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class neighbor_scoreboard;
    bit                grid_blocked [0:MaxRowsDef-1][0:MaxColsDef-1];
    logic [CountW-1:0] row_reg;
    logic [CountW-1:0] col_reg;
    out_item_t         expected_neighbors [$];
    int                n_errors;
    int                n_writes;
    int                n_queries;
    int                n_results;

    function new();
      row_reg = RowCountRst;
      col_reg = ColumnCountRst;
    endfunction

    function int eff_count(input logic [CountW-1:0] v, input int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
    endfunction

    function void set_count(input logic idx, input logic [CountW-1:0] v);
      if (idx == RegRowCount) row_reg = v;
      else col_reg = v;
    endfunction

    function void compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
        n_errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    // Called for every accepted input transfer, in order.
    function void note_transfer(input in_item_t it);
      int        rows;
      int        cols;
      int        r;
      int        c;
      int        nr;
      int        nc;
      int        k;
      out_item_t e;
      if (it.op == OpWrite) begin
        grid_blocked[it.cell_row][it.cell_col] = it.cell_blocked;
        n_writes++;
        return;
      end
      n_queries++;
      rows = eff_count(row_reg, MaxRowsDef);
      cols = eff_count(col_reg, MaxColsDef);
      r = int'(it.node_id) / cols;
      c = int'(it.node_id) % cols;
      for (k = 0; k < 4; k++) begin
        nr = r;
        nc = c;
        case (move_e'(k))
          MoveUp:    nr = r - 1;
          MoveDown:  nr = r + 1;
          MoveRight: nc = c + 1;
          default:   nc = c - 1;
        endcase
        e = '0;
        // The query node itself may lie beyond the rows in use; only the
        // neighbour is tested against the border.
        if (nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
          e.neighbor_id    = IdW'(nr * cols + nc);
          e.neighbor_valid = !grid_blocked[nr][nc];
        end
        e.move_index = 2'(k);
        e.last       = (k == 3);
        expected_neighbors = {expected_neighbors, e};
      end
    endfunction

    function void check_result(input out_item_t got);
      out_item_t e;
      n_results++;
      if (expected_neighbors.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        return;
      end
      e = expected_neighbors.pop_front();
      compare_field("neighbor_id", e.neighbor_id, got.neighbor_id);
      compare_field("neighbor_valid", e.neighbor_valid, got.neighbor_valid);
      compare_field("move_index", e.move_index, got.move_index);
      compare_field("last", e.last, got.last);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  neighbor_scoreboard sb = new();
  bit tx_quiet;
  bit rx_quiet;
  bit hold_request;
  int n_shapes;

  grid_neighbor_expander_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end

  // Output side: check each transfer, then choose the stall for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        sb.check_result(out_item_o);
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_request) begin
        hold_left    = 250;
        hold_request = 1'b0;
      end
      out_stall_i <= (hold_left > 0) || (!rx_quiet && $urandom_range(0, 99) < 33);
    end
  end

  task automatic apb_transfer(input logic wr, input logic idx,
                              input logic [ApbDataW-1:0] wdata,
                              output logic [ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper data bits are random, as the register only keeps the low bits.
  task automatic write_count(input logic idx, input logic [CountW-1:0] val);
    logic [ApbDataW-1:0] wdata;
    logic [ApbDataW-1:0] rdata;
    wdata = $urandom;
    wdata[CountW-1:0] = val;
    apb_transfer(1'b1, idx, wdata, rdata);
    sb.set_count(idx, val);
    apb_transfer(1'b0, idx, '0, rdata);
    sb.compare_field("register readback", val, rdata[CountW-1:0]);
  endtask

  task automatic set_shape(input logic [CountW-1:0] rows, input logic [CountW-1:0] cols);
    write_count(RegRowCount, rows);
    write_count(RegColumnCount, cols);
    n_shapes++;
  endtask

  task automatic send_item(input in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_transfer(it);
    if (!tx_quiet && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic end_stream();
    in_valid_i <= 1'b0;
    while (sb.expected_neighbors.size() != 0) @(posedge clk_i);
    // A trailing cell write or a late query may still be in flight.
    repeat (30) @(posedge clk_i);
  endtask

  // Fields that the operation ignores are left random.
  function automatic in_item_t cell_write(input int r, input int c, input bit b);
    in_item_t it;
    it              = in_item_t'($urandom);
    it.op           = OpWrite;
    it.cell_row     = CellW'(r);
    it.cell_col     = CellW'(c);
    it.cell_blocked = b;
    return it;
  endfunction

  function automatic in_item_t node_query(input int n);
    in_item_t it;
    it         = in_item_t'($urandom);
    it.op      = OpQuery;
    it.node_id = NodeW'(n);
    return it;
  endfunction

  task automatic random_phase(input int n_items);
    int rows;
    int cols;
    int i;
    rows = sb.eff_count(sb.row_reg, MaxRowsDef);
    cols = sb.eff_count(sb.col_reg, MaxColsDef);
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 40) begin
        // Mostly cells in use, so that queries meet obstacles.
        if ($urandom_range(0, 99) < 75) begin
          send_item(cell_write($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                               $urandom_range(0, 99) < 35));
        end else begin
          send_item(cell_write($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 1)));
        end
      end else if ($urandom_range(0, 99) < 70) begin
        send_item(node_query($urandom_range(0, rows * cols - 1)));
      end else begin
        send_item(node_query($urandom_range(0, 4095)));
      end
    end
    end_stream();
  endtask

  initial begin
    logic [CountW-1:0] shape_rows [7];
    logic [CountW-1:0] shape_cols [7];
    int p;
    shape_rows = '{5, 1, 64, 127, 3, 0, 64};
    shape_cols = '{7, 64, 1, 0, 4, 0, 64};
    shape_rows[5] = CountW'($urandom_range(0, 127));
    shape_cols[5] = CountW'($urandom_range(0, 127));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset shape: corners, edges and blocked neighbours.
    n_shapes = 1;
    send_item(cell_write(0, 1, 1'b1));
    send_item(cell_write(1, 0, 1'b1));
    send_item(node_query(0));
    send_item(cell_write(62, 63, 1'b1));
    send_item(node_query(4095));
    send_item(node_query(63));
    send_item(node_query(64));
    send_item(cell_write(0, 1, 1'b0));
    send_item(node_query(0));
    send_item(cell_write(63, 63, 1'b1));
    send_item(node_query(4031));
    end_stream();

    // Zero counts act as a single cell.
    set_shape(0, 0);
    send_item(node_query(0));
    send_item(node_query(4095));
    end_stream();

    // Oversized column count saturates; queries from the row just past the
    // grid may still reach a valid neighbour above.
    set_shape(2, 127);
    send_item(cell_write(1, 0, 1'b0));
    send_item(node_query(128));
    send_item(node_query(129));
    send_item(node_query(191));
    end_stream();

    for (p = 0; p < 7; p++) begin
      set_shape(shape_rows[p], shape_cols[p]);
      tx_quiet = (p == 2) || (p == 4);
      rx_quiet = (p == 4);
      if (p == 2) hold_request = 1'b1;
      random_phase(22);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    $display("Covered %0d cell writes and %0d queries (%0d neighbour results) over %0d grid shapes,",
             sb.n_writes, sb.n_queries, sb.n_results, n_shapes);
    $display("including zero and oversized counts and a long output hold-off.");
    if (sb.n_errors == 0 && sb.expected_neighbors.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== grid_neighbor_expander_core.f =====
rtl/core/gne_pkg.sv
rtl/core/gne_divider.sv
rtl/core/grid_neighbor_expander_core.sv
test/grid_neighbor_expander_core_tb.sv
